>>> src/bg3_pkg.sv
package bg3_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_COLS      = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int THR_W      = 4;
    localparam int POS_W      = 6;

    localparam logic [THR_W-1:0]      THRESHOLD_RESET = 4'd4;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET      = 7'd64;
    localparam int                    MIN_SIZE        = 3;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             alive;
        logic             last;
        logic             done;
    } t_result;

endpackage

>>> src/bg3_line_mem.sv
// Two stacked line stores in one memory word: bit 1 = previous row, bit 0 = row before.
// Read-modify-write: the read word is registered, the write shifts the new cell in.
module bg3_line_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_wr_cell,
    output logic                     o_up1,
    output logic                     o_up2
);

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_cell, r_rd[1]};
        end
    end

    assign o_up1 = r_rd[1];
    assign o_up2 = r_rd[0];

endmodule

>>> src/binary_grid_3x3_threshold_step_unit.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+------------------------------------------
// input    | in        | i_valid / o_stall         | i_cell_in
// result   | out       | o_valid / i_stall         | o_out_row o_out_col o_cell_out
//          |           |                           | o_last_of_run o_frame_done
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// One cell request per cycle sustained while the result side does not stall; two stages
// (line memory read, then window update and result build). A cell that yields two results
// (interior plus border) holds the input while both drain; the result port moves one per cycle.
// Reset is synchronous, active low; line memory contents are not cleared.
// A stall on the result side backs up through the output slots into o_stall.
module binary_grid_3x3_threshold_step_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cell input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_cell_in,
    // results
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [bg3_pkg::POS_W-1:0]        o_out_row,
    output logic [bg3_pkg::POS_W-1:0]        o_out_col,
    output logic                             o_cell_out,
    output logic                             o_last_of_run,
    output logic                             o_frame_done,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bg3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bg3_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CSW = (CW + 1 > bg3_pkg::CFG_DATA_W) ? CW + 1 : bg3_pkg::CFG_DATA_W;
    localparam int RSW = (RW + 1 > bg3_pkg::CFG_DATA_W) ? RW + 1 : bg3_pkg::CFG_DATA_W;

    // configuration registers
    logic [bg3_pkg::THR_W-1:0]      r_thr;
    logic [bg3_pkg::CFG_DATA_W-1:0] r_rows;
    logic [bg3_pkg::CFG_DATA_W-1:0] r_cols;

    // position of the next cell to arrive
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;

    // stage 1: cell whose line memory read is in flight
    logic          r_s1_v;
    logic [RW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_cell;

    logic [8:0]    r_win;

    // output slots: slot0 is on the port, slot1 queued behind it
    bg3_pkg::t_result r_slot0;
    bg3_pkg::t_result r_slot1;
    logic [1:0]       r_out_cnt;

    logic [CSW-1:0] cols_ext, ncols;
    logic [RSW-1:0] rows_ext, nrows;
    logic [CW-1:0]  last_col;
    logic [RW-1:0]  last_row;

    logic           in_acc, cfg_wr, size_wr;
    logic           up1, up2;
    logic [8:0]     win_new;
    logic [bg3_pkg::THR_W-1:0] cnt9;
    logic           due, border, pop, s1_go;
    logic [1:0]     res_n, cnt_after;
    bg3_pkg::t_result res_int, res_bdr, res_a, res_b;

    // saturate the sizes to MIN_SIZE..MAX
    always_comb begin
        cols_ext = CSW'(r_cols);
        rows_ext = RSW'(r_rows);
        if (cols_ext < CSW'(bg3_pkg::MIN_SIZE)) begin
            ncols = CSW'(bg3_pkg::MIN_SIZE);
        end else if (cols_ext > CSW'(MAX_COLS)) begin
            ncols = CSW'(MAX_COLS);
        end else begin
            ncols = cols_ext;
        end
        if (rows_ext < RSW'(bg3_pkg::MIN_SIZE)) begin
            nrows = RSW'(bg3_pkg::MIN_SIZE);
        end else if (rows_ext > RSW'(MAX_ROWS)) begin
            nrows = RSW'(MAX_ROWS);
        end else begin
            nrows = rows_ext;
        end
    end

    assign last_col = CW'(ncols - CSW'(1));
    assign last_row = RW'(nrows - RSW'(1));

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign size_wr     = cfg_wr
                      && (i_cfg_index inside {bg3_pkg::CFG_ROWS, bg3_pkg::CFG_COLS});

    assign in_acc = i_valid && !o_stall;

    // Each column is read at accept and written back when its stage-1 slot retires.
    // The same column comes back at least three requests later, after the write.
    bg3_line_mem #(
        .DEPTH (MAX_COLS)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_cell (r_s1_cell),
        .o_up1     (up1),
        .o_up2     (up2)
    );

    // window and result build for the stage-1 cell
    always_comb begin
        win_new = {r_win[5:0], up2, up1, r_s1_cell};
        cnt9    = bg3_pkg::THR_W'($countones(win_new));
        due     = (r_s1_row >= RW'(2)) && (r_s1_col >= CW'(2));
        border  = (r_s1_row == '0) || (r_s1_col == '0)
               || (r_s1_row == last_row) || (r_s1_col == last_col);

        res_int.row   = bg3_pkg::POS_W'(r_s1_row - RW'(1));
        res_int.col   = bg3_pkg::POS_W'(r_s1_col - CW'(1));
        res_int.alive = (cnt9 > r_thr);
        res_int.last  = !border;
        res_int.done  = 1'b0;

        res_bdr.row   = bg3_pkg::POS_W'(r_s1_row);
        res_bdr.col   = bg3_pkg::POS_W'(r_s1_col);
        res_bdr.alive = r_s1_cell;
        res_bdr.last  = 1'b1;
        res_bdr.done  = (r_s1_row == last_row) && (r_s1_col == last_col);

        // interior result goes first when both are due
        res_a = due ? res_int : res_bdr;
        res_b = res_bdr;
        res_n = {1'b0, due} + {1'b0, border};
    end

    assign pop       = (r_out_cnt != 2'd0) && !i_stall;
    assign cnt_after = r_out_cnt - {1'b0, pop};
    // results load only into empty slots; a cell with no result retires freely
    assign s1_go     = r_s1_v && ((res_n == 2'd0) || (cnt_after == 2'd0));
    assign o_stall   = r_s1_v && !s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= bg3_pkg::THRESHOLD_RESET;
            r_rows    <= bg3_pkg::SIZE_RESET;
            r_cols    <= bg3_pkg::SIZE_RESET;
            r_row     <= '0;
            r_col     <= '0;
            r_s1_v    <= 1'b0;
            r_win     <= '0;
            r_out_cnt <= 2'd0;
        end else begin
            if (cfg_wr) begin
                case (i_cfg_index)
                    bg3_pkg::CFG_THRESHOLD: r_thr  <= i_cfg_data[bg3_pkg::THR_W-1:0];
                    bg3_pkg::CFG_ROWS:      r_rows <= i_cfg_data;
                    bg3_pkg::CFG_COLS:      r_cols <= i_cfg_data;
                    default: ;
                endcase
            end

            // raster position, restarted by a size write
            if (size_wr) begin
                r_row <= '0;
                r_col <= '0;
            end else if (in_acc) begin
                if (r_col == last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == last_row) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end

            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end

            if (size_wr) begin
                r_win <= '0;
            end else if (s1_go) begin
                r_win <= win_new;
            end

            if (s1_go && (res_n != 2'd0)) begin
                r_out_cnt <= res_n;
            end else if (pop) begin
                r_out_cnt <= r_out_cnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_cell <= i_cell_in;
        end
        if (s1_go && (res_n != 2'd0)) begin
            r_slot0 <= res_a;
            r_slot1 <= res_b;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_valid       = (r_out_cnt != 2'd0);
    assign o_out_row     = r_slot0.row;
    assign o_out_col     = r_slot0.col;
    assign o_cell_out    = r_slot0.alive;
    assign o_last_of_run = r_slot0.last;
    assign o_frame_done  = r_slot0.done;

endmodule

>>> src/bg3_checker.sv
module bg3_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [bg3_pkg::POS_W-1:0]      o_out_row,
    input logic [bg3_pkg::POS_W-1:0]      o_out_col,
    input logic                           o_cell_out,
    input logic                           o_last_of_run,
    input logic                           o_frame_done
);

    // frame end is always the final result of its request
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    // interior result is followed at once, when not stalled, by the border cell one column on
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run && !i_stall) |=>
        (o_valid && o_last_of_run && (o_out_col == $past(o_out_col) + 6'd1)))
        else $error("second result of a pair missing or misplaced");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_out_row) && $stable(o_out_col) && $stable(o_cell_out)
         && $stable(o_last_of_run) && $stable(o_frame_done)))
        else $error("stalled result changed");

endmodule

bind binary_grid_3x3_threshold_step_unit bg3_checker u_bg3_checker (.*);
